### hdl/coo_spmv_pkg.sv
// coo_spmv_pkg: shared types and constants for the COO SpMV row accumulator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package coo_spmv_pkg;

	localparam int VECTOR_LEN_DEF = 4096;
	localparam int ROW_W = 20;
	localparam int COL_W = 12;
	localparam int WORD_W = 32;

	// queue between front and back, and the result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_DEPTH = 4;

	localparam logic MODE_VEC_LOAD = 1'b0;
	localparam logic MODE_NONZERO = 1'b1;

	typedef struct packed {
		logic mode;
		logic [ROW_W-1:0] row_index;
		logic [COL_W-1:0] col_index;
		logic signed [WORD_W-1:0] value;
		logic last_nonzero;
	} in_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		logic signed [WORD_W-1:0] row_sum;
		logic final_res;
	} out_item_t;

	// one classified nonzero, product already formed
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [WORD_W-1:0] prod;
		logic last;
	} nz_item_t;

endpackage

### hdl/coo_spmv_row_accumulator.sv
// coo_spmv_row_accumulator: top level of the COO sparse matrix-vector row accumulator.
// Depends on coo_spmv_pkg, coo_spmv_front, coo_spmv_back and coo_spmv_fifo.
//
// Input channel: item (mode, row_index, col_index, value, last_nonzero) is taken
// at a clock edge with push high and full low. Mode 0 loads vector[col_index];
// mode 1 is a nonzero of a row-sorted stream.
// Result channel: result (out_row, row_sum, final_res) holds the oldest result
// while empty is low; pop with empty low takes it.
// row_base is loaded at any edge with row_base_we high; change it only while idle.
// A result follows the nonzero that causes it through the vector read, the multiply
// and the accumulate step. The input takes one item per clock while full is low; a
// last nonzero that also changes row closes the open row first, then gives its own.
// The vector store port (one write or one read per accepted item) sets the rate.
// When pop stays low the four-entry result queue fills, the accumulator halts,
// the four-entry nonzero queue fills and full rises.
// Reset clears row_base, the running sum, the open-row state and both queues;
// vector contents are undefined until loaded.
`timescale 1ns / 1ps

module coo_spmv_row_accumulator
	import coo_spmv_pkg::*;
#(
	parameter int VECTOR_LEN = VECTOR_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_item_t item,
	input  logic row_base_we,
	input  logic [ROW_W-1:0] row_base,
	output logic empty,
	input  logic pop,
	output out_item_t result
);

	logic [ROW_W-1:0] row_base_q;

	logic nz_valid;
	nz_item_t nz_in;
	nz_item_t nz_head;
	logic nz_empty;
	logic nz_pop;
	logic [QCNT_W-1:0] nz_count;

	logic res_push;
	logic res_full;
	out_item_t res_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_base_q <= '0;
		end else if (row_base_we) begin
			row_base_q <= row_base;
		end
	end

	coo_spmv_front #(
		.VECTOR_LEN(VECTOR_LEN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.q_count(nz_count),
		.nz_valid(nz_valid),
		.nz_item(nz_in)
	);

	// the front's credit count keeps this queue from overflowing
	coo_spmv_fifo #(
		.T(nz_item_t),
		.DEPTH(QUEUE_DEPTH)
	) u_nz_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(nz_valid),
		.wr_data(nz_in),
		.rd_en(nz_pop),
		.rd_data(nz_head),
		.is_full(),
		.is_empty(nz_empty),
		.count(nz_count)
	);

	coo_spmv_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.row_base(row_base_q),
		.nz_avail(!nz_empty),
		.nz_item(nz_head),
		.nz_pop(nz_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res_item(res_item)
	);

	coo_spmv_fifo #(
		.T(out_item_t),
		.DEPTH(OUT_DEPTH)
	) u_res_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(res_push),
		.wr_data(res_item),
		.rd_en(pop),
		.rd_data(result),
		.is_full(res_full),
		.is_empty(empty),
		.count()
	);

endmodule

### hdl/coo_spmv_fifo.sv
// coo_spmv_fifo: small register-based queue with push/pop and a fill count.
// Depends on coo_spmv_pkg (nothing but the house import); DEPTH is a power of two.
`timescale 1ns / 1ps

module coo_spmv_fifo
	import coo_spmv_pkg::*;
#(
	parameter type T = logic,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T wr_data,
	input  logic rd_en,
	output T rd_data,
	output logic is_full,
	output logic is_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign is_full = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign count = count_q;
	assign rd_data = slots_q[rd_ptr_q];
	assign do_wr = wr_en && !is_full;
	assign do_rd = rd_en && !is_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) slots_q[wr_ptr_q] <= wr_data;
	end

endmodule

### hdl/coo_spmv_front.sv
// coo_spmv_front: accepts items, owns the vector store, forms the products.
// Depends on coo_spmv_pkg; feeds the nonzero queue through a credit count.
`timescale 1ns / 1ps

module coo_spmv_front
	import coo_spmv_pkg::*;
#(
	parameter int VECTOR_LEN = VECTOR_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  in_item_t item,
	output logic full,
	input  logic [QCNT_W-1:0] q_count,
	output logic nz_valid,
	output nz_item_t nz_item
);

	localparam int AW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
	localparam int EXT_W = 17;

	logic [WORD_W-1:0] vec_mem [VECTOR_LEN];

	logic accept;
	logic [EXT_W-1:0] col_ext;
	logic in_range;
	logic [AW-1:0] addr;
	logic [QCNT_W-1:0] occupancy;

	logic valid_s1;
	logic in_range_s1;
	logic [ROW_W-1:0] row_s1;
	logic [WORD_W-1:0] val_s1;
	logic last_s1;
	logic [WORD_W-1:0] rd_s1;
	logic [WORD_W-1:0] x_s1;

	logic valid_s2;
	logic [ROW_W-1:0] row_s2;
	logic [WORD_W-1:0] prod_s2;
	logic last_s2;

	// credit: queue entries plus nonzeros still in the two pipeline stages
	assign occupancy = q_count + QCNT_W'(valid_s1) + QCNT_W'(valid_s2);
	assign full = (occupancy >= QCNT_W'(QUEUE_DEPTH));
	assign accept = push && !full;

	assign col_ext = EXT_W'(item.col_index);
	assign in_range = (col_ext < EXT_W'(VECTOR_LEN));
	assign addr = col_ext[AW-1:0];

	always_ff @(posedge clk) begin
		if (accept && item.mode == MODE_VEC_LOAD && in_range) begin
			vec_mem[addr] <= item.value;
		end
		if (accept && item.mode == MODE_NONZERO) begin
			rd_s1 <= vec_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept && item.mode == MODE_NONZERO;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_s1 <= in_range;
			row_s1 <= item.row_index;
			val_s1 <= item.value;
			last_s1 <= item.last_nonzero;
		end
		row_s2 <= row_s1;
		last_s2 <= last_s1;
		prod_s2 <= WORD_W'(val_s1 * x_s1);
	end

	// columns past the vector read as zero
	assign x_s1 = in_range_s1 ? rd_s1 : '0;

	assign nz_valid = valid_s2;
	assign nz_item.row = row_s2;
	assign nz_item.prod = prod_s2;
	assign nz_item.last = last_s2;

endmodule

### hdl/coo_spmv_back.sv
// coo_spmv_back: row accumulator; closes rows and pushes results.
// Depends on coo_spmv_pkg; reads the nonzero queue, writes the result queue.
`timescale 1ns / 1ps

module coo_spmv_back
	import coo_spmv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [ROW_W-1:0] row_base,
	input  logic nz_avail,
	input  nz_item_t nz_item,
	output logic nz_pop,
	input  logic res_full,
	output logic res_push,
	output out_item_t res_item
);

	logic [WORD_W-1:0] acc_q;
	logic [ROW_W-1:0] cur_row_q;
	logic open_q;

	logic go;
	logic need_close;
	logic [WORD_W-1:0] sum;

	assign go = nz_avail && !res_full;
	assign need_close = open_q && (nz_item.row != cur_row_q);
	assign sum = acc_q + nz_item.prod;

	always_comb begin
		nz_pop = 1'b0;
		res_push = 1'b0;
		res_item.out_row = cur_row_q - row_base;
		res_item.row_sum = acc_q;
		res_item.final_res = 1'b0;
		if (go) begin
			if (need_close) begin
				res_push = 1'b1;
				// a last nonzero that also changes row stays at the head while the open row closes
				nz_pop = !nz_item.last;
			end else begin
				nz_pop = 1'b1;
				if (nz_item.last) begin
					res_push = 1'b1;
					res_item.out_row = nz_item.row - row_base;
					res_item.row_sum = sum;
					res_item.final_res = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cur_row_q <= '0;
			open_q <= 1'b0;
		end else if (go) begin
			cur_row_q <= nz_item.row;
			if (need_close) begin
				acc_q <= nz_item.last ? '0 : nz_item.prod;
			end else if (nz_item.last) begin
				acc_q <= '0;
				open_q <= 1'b0;
			end else begin
				acc_q <= sum;
				open_q <= 1'b1;
			end
		end
	end

endmodule

### hdl/coo_spmv_chk.sv
// coo_spmv_chk: port-level assertions for coo_spmv_row_accumulator, bound to the top.
// Depends on coo_spmv_pkg and the top level's port list.
`timescale 1ns / 1ps

module coo_spmv_chk
	import coo_spmv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  logic empty,
	input  logic pop,
	input  out_item_t result
);

	// all queues and credits are clear while reset stays asserted
	a_reset_clear: assert property (@(posedge clk) !arst_n && $past(!arst_n) |->
		empty && !full)
		else $error("queues not clear in reset");

	// full only rises after an input transaction took a credit
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an input transaction");

	// a waiting result holds until popped
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed or vanished");

endmodule

bind coo_spmv_row_accumulator coo_spmv_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.push(push),
	.full(full),
	.empty(empty),
	.pop(pop),
	.result(result)
);

### tb/coo_spmv_row_checker.sv
// coo_spmv_row_checker: watches both queue channels of the COO SpMV row accumulator,
// predicts every row result from the accepted items and compares the popped results.
// Depends on coo_spmv_pkg for the item types and widths.
`timescale 1ns / 1ps

module coo_spmv_row_checker
	import coo_spmv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  in_item_t item,
	input  logic row_base_we,
	input  logic [ROW_W-1:0] row_base,
	input  logic empty,
	input  logic pop,
	input  out_item_t result,
	output int mismatches,
	output int pending
);

	logic [WORD_W-1:0] vec_mem [0:VECTOR_LEN_DEF-1];
	logic [WORD_W-1:0] sum_acc;
	logic [ROW_W-1:0] open_row;
	logic row_open;
	logic [ROW_W-1:0] cur_base;
	out_item_t row_results_q [$];

	task automatic queue_row_result(input logic [ROW_W-1:0] row, input logic fin);
		out_item_t res;
		res.out_row = row - cur_base;
		res.row_sum = sum_acc;
		res.final_res = fin;
		row_results_q.push_back(res);
	endtask

	task automatic accumulate_item(input in_item_t it);
		logic [WORD_W-1:0] vec_word;
		logic [WORD_W-1:0] product;
		if (it.mode == MODE_VEC_LOAD) begin
			vec_mem[it.col_index] = it.value;
		end else begin
			// any change of row closes the open one, upward or backward
			if (row_open && it.row_index != open_row) begin
				queue_row_result(open_row, 1'b0);
				sum_acc = '0;
			end
			open_row = it.row_index;
			row_open = 1'b1;
			vec_word = vec_mem[it.col_index];
			product = it.value * vec_word;
			sum_acc = sum_acc + product;
			if (it.last_nonzero) begin
				queue_row_result(open_row, 1'b1);
				sum_acc = '0;
				row_open = 1'b0;
			end
		end
	endtask

	task automatic check_row_result(input out_item_t got);
		out_item_t want;
		if (row_results_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result row %0d sum %0d final %0b",
					$realtime, got.out_row, got.row_sum, got.final_res);
		end else begin
			want = row_results_q.pop_front();
			if (got.out_row !== want.out_row || got.row_sum !== want.row_sum ||
					got.final_res !== want.final_res) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result mismatch: expected row %0d sum %0d final %0b,",
						$realtime, want.out_row, want.row_sum, want.final_res,
						" got row %0d sum %0d final %0b",
						got.out_row, got.row_sum, got.final_res);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_acc = '0;
			open_row = '0;
			row_open = 1'b0;
			cur_base = '0;
			row_results_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (pop && !empty)
				check_row_result(result);
			if (push && !full)
				accumulate_item(item);
			if (row_base_we)
				cur_base = row_base;
			pending = row_results_q.size();
		end
	end

endmodule

### tb/coo_spmv_row_accumulator_tb.sv
// coo_spmv_row_accumulator_tb: stimulus and verdict for the COO SpMV row accumulator.
// Depends on coo_spmv_pkg, coo_spmv_row_accumulator and coo_spmv_row_checker.
`timescale 1ns / 1ps

module coo_spmv_row_accumulator_tb;
	import coo_spmv_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	in_item_t item;
	logic row_base_we;
	logic [ROW_W-1:0] row_base;
	logic empty;
	logic pop;
	out_item_t result;

	int mismatches;
	int pending;
	int cycle_count;
	int snd_idle_pct;
	int rcv_stall_pct;
	int rcv_hold;

	bit col_loaded [0:VECTOR_LEN_DEF-1];
	int loaded_cols [$];
	logic [ROW_W-1:0] walk_row;

	always #2 clk = ~clk;

	coo_spmv_row_accumulator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.row_base_we(row_base_we),
		.row_base(row_base),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	coo_spmv_row_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.row_base_we(row_base_we),
		.row_base(row_base),
		.empty(empty),
		.pop(pop),
		.result(result),
		.mismatches(mismatches),
		.pending(pending)
	);

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 19))
			0: rand_word = 32'h7FFF_FFFF;
			1: rand_word = 32'h8000_0000;
			2: rand_word = 32'h0000_0000;
			3: rand_word = 32'hFFFF_FFFF;
			4: rand_word = $urandom_range(0, 15);
			default: rand_word = $urandom;
		endcase
	endfunction

	function automatic in_item_t vec_load(input logic [COL_W-1:0] col,
			input logic [WORD_W-1:0] val, input logic last, input logic [ROW_W-1:0] row);
		vec_load.mode = MODE_VEC_LOAD;
		vec_load.row_index = row;
		vec_load.col_index = col;
		vec_load.value = val;
		vec_load.last_nonzero = last;
	endfunction

	function automatic in_item_t nonzero(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [WORD_W-1:0] val, input logic last);
		nonzero.mode = MODE_NONZERO;
		nonzero.row_index = row;
		nonzero.col_index = col;
		nonzero.value = val;
		nonzero.last_nonzero = last;
	endfunction

	// only columns already loaded are read, the store is undefined otherwise
	function automatic logic [COL_W-1:0] loaded_col();
		loaded_col = COL_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
	endfunction

	task automatic offer_item(input in_item_t it);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (it.mode == MODE_VEC_LOAD && !col_loaded[it.col_index]) begin
			col_loaded[it.col_index] = 1'b1;
			loaded_cols.push_back(int'(it.col_index));
		end
	endtask

	// drop push, let every result drain, then allow the pipeline to settle
	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		wait (pending == 0);
		repeat (8)
			@(negedge clk);
	endtask

	task automatic write_row_base(input logic [ROW_W-1:0] val);
		drain_results();
		row_base_we <= 1'b1;
		row_base <= val;
		@(negedge clk);
		row_base_we <= 1'b0;
		walk_row = val + ROW_W'($urandom_range(0, 8));
	endtask

	task automatic run_stream_mix(input int n_items);
		in_item_t it;
		int k;
		int step;
		for (k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 99) < 12 || loaded_cols.size() == 0) begin
				it = vec_load(COL_W'($urandom_range(0, VECTOR_LEN_DEF - 1)), rand_word(),
					1'($urandom_range(0, 1)), ROW_W'($urandom));
			end else begin
				step = $urandom_range(0, 99);
				if (step < 55)
					walk_row = walk_row;
				else if (step < 85)
					walk_row = walk_row + ROW_W'($urandom_range(1, 3));
				else if (step < 93)
					walk_row = walk_row - ROW_W'($urandom_range(1, 4));
				else
					walk_row = ROW_W'($urandom);
				it = nonzero(walk_row, loaded_col(), rand_word(),
					$urandom_range(0, 99) < 6);
			end
			offer_item(it);
		end
		// close the stream so no row stays open across a register write
		offer_item(nonzero(walk_row, loaded_col(), rand_word(), 1'b1));
	endtask

	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (rcv_hold > 0) begin
				pop <= 1'b0;
				rcv_hold--;
			end else begin
				pop <= ($urandom_range(0, 99) >= rcv_stall_pct);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("coo_spmv_row_accumulator test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		row_base_we = 1'b0;
		row_base = '0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		rcv_hold = 0;
		walk_row = '0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_row_base('0);

		// directed: extremes, ignored last mark on a load, row changes both ways
		offer_item(vec_load(0, 32'h7FFF_FFFF, 1'b1, 20'hFFFFF));
		offer_item(vec_load(4095, 32'h8000_0000, 1'b0, '0));
		offer_item(vec_load(1, 32'hFFFF_FFFF, 1'b0, '0));
		offer_item(vec_load(2, 32'd3, 1'b0, '0));
		offer_item(vec_load(4094, 32'd0, 1'b1, '0));
		offer_item(nonzero(0, 0, 32'h7FFF_FFFF, 1'b0));
		offer_item(nonzero(0, 4095, 32'h8000_0000, 1'b0));
		offer_item(nonzero(0, 1, 32'hFFFF_FFFF, 1'b0));
		offer_item(nonzero(9, 2, 32'd7, 1'b0));
		offer_item(nonzero(3, 4094, 32'd12345, 1'b0));
		// row change and last mark together give two results
		offer_item(nonzero(20'hFFFFF, 1, 32'h8000_0000, 1'b1));
		offer_item(nonzero(20'hFFFFF, 0, 32'd1, 1'b1));
		// vector write immediately followed by a read of the same element
		offer_item(vec_load(3, 32'd5, 1'b0, '0));
		offer_item(nonzero(7, 3, 32'hFFFF_FFFE, 1'b0));
		offer_item(vec_load(3, 32'd11, 1'b0, '0));
		offer_item(nonzero(7, 3, 32'd1, 1'b0));
		offer_item(nonzero(7, 2, 32'h8000_0000, 1'b1));

		write_row_base(20'hFFFFF);
		offer_item(nonzero(20'h00000, 4095, 32'hFFFF_FFFF, 1'b1));
		offer_item(nonzero(20'hFFFFF, 0, 32'h7FFF_FFFF, 1'b1));
		run_stream_mix(40);
		// receiver holds off while the sender keeps pushing
		rcv_hold = 80;
		run_stream_mix(95);

		snd_idle_pct = 49;
		write_row_base(ROW_W'($urandom));
		run_stream_mix(135);

		snd_idle_pct = 0;
		rcv_stall_pct = 49;
		write_row_base('0);
		run_stream_mix(135);

		snd_idle_pct = 31;
		rcv_stall_pct = 31;
		write_row_base(ROW_W'($urandom));
		run_stream_mix(135);

		drain_results();
		repeat (12)
			@(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("coo_spmv_row_accumulator test passed");
		else
			$display("coo_spmv_row_accumulator test failed");
		$finish;
	end

endmodule
